[hw/rtl/pxcc_pkg.sv]
// pxcc_pkg: shared types and constants for the packet xor checksum checker
// request structs for both channels, parser phase codes, counter width
// no dependencies
`default_nettype none

package pxcc_pkg;

  // width of the running packet and error totals (reported in their low 32 bits)
  localparam int unsigned CounterBits = 32;

  // header is three 32-bit words
  localparam int unsigned HeaderBytes = 3 * 4;

  // input request: one byte of the packet stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } pxcc_in_t;

  // output request: one report per finished packet
  typedef struct packed {
    logic [31:0] packet_index;
    logic        checksum_ok;
    logic        truncated;
    logic [31:0] packets_seen;
    logic [31:0] errors_seen;
    logic [31:0] last_good_index;
  } pxcc_out_t;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_INDEX   = 4'b0001,
    PH_CHECK   = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } pxcc_phase_e;

endpackage

`default_nettype wire

[hw/rtl/pxcc_in_stage.sv]
// pxcc_in_stage: input register for byte requests
// depends on pxcc_pkg for the input request struct
`default_nettype none

module pxcc_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pxcc_pkg::pxcc_in_t in_data_i,
  input  wire logic               take_i,
  output logic                    held_valid_o,
  output pxcc_pkg::pxcc_in_t      held_data_o
);
  import pxcc_pkg::*;

  logic     valid_q, valid_d;
  pxcc_in_t data_q;
  logic     load;

  // slot is free when empty or drained this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

endmodule

`default_nettype wire

[hw/rtl/pxcc_parser.sv]
// pxcc_parser: packet parser state, xor accumulation and running totals
// one byte per step; depends on pxcc_pkg for types and counter width
`default_nettype none

module pxcc_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire pxcc_pkg::pxcc_in_t byte_i,
  output logic                    res_valid_o,
  output pxcc_pkg::pxcc_out_t     res_o
);
  import pxcc_pkg::*;

  pxcc_phase_e            phase_q, phase_d;
  logic [1:0]             pos_q, pos_d;
  logic [23:0]            gather_q, gather_d;
  logic [31:0]            remain_q, remain_d;
  logic [31:0]            xor_q, xor_d;
  logic [31:0]            expect_q, expect_d;
  logic [31:0]            index_q, index_d;
  logic [CounterBits-1:0] pkt_total_q, pkt_total_d;
  logic [CounterBits-1:0] err_total_q, err_total_d;
  logic [31:0]            good_q, good_d;

  logic        word_done;
  logic [31:0] word;
  logic        finished;
  logic        fire;
  logic        ok;
  logic        trunc;
  logic [31:0] rep_index;

  always_comb begin
    // word assembly, big-endian
    word_done = (pos_q == 2'd3);
    word      = {gather_q, byte_i.data_byte};
    pos_d     = pos_q + 2'd1;
    gather_d  = word_done ? 24'd0 : {gather_q[15:0], byte_i.data_byte};

    phase_d  = phase_q;
    remain_d = remain_q;
    xor_d    = xor_q;
    expect_d = expect_q;
    index_d  = index_q;
    finished = 1'b0;

    // header and payload phases
    case (phase_q)
      PH_INDEX: begin
        if (word_done) begin
          index_d = word;
          xor_d   = word;
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (word_done) begin
          expect_d = word;
          phase_d  = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (word_done) begin
          remain_d = word;
          if (word == 32'd0) begin
            finished = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (word_done) begin
          xor_d = xor_q ^ word;
        end
        remain_d = remain_q - 32'd1;
        if (remain_d == 32'd0) begin
          finished = 1'b1;
        end
      end
      default: begin
        phase_d = PH_INDEX;
      end
    endcase

    // report on packet end or buffer end
    fire      = finished || byte_i.end_of_buffer;
    ok        = finished && (xor_d == expect_d);
    trunc     = !finished;
    rep_index = (!finished && phase_d == PH_INDEX) ? 32'd0 : index_d;

    pkt_total_d = pkt_total_q;
    err_total_d = err_total_q;
    good_d      = good_q;
    if (fire) begin
      pkt_total_d = pkt_total_q + 1'b1;
      if (ok) begin
        good_d = rep_index;
      end else begin
        err_total_d = err_total_q + 1'b1;
      end
      // restart at an index word
      phase_d  = PH_INDEX;
      pos_d    = 2'd0;
      gather_d = 24'd0;
      remain_d = 32'd0;
      xor_d    = 32'd0;
    end
  end

  // result to the output register
  assign res_valid_o           = step_i && fire;
  assign res_o.packet_index    = rep_index;
  assign res_o.checksum_ok     = ok;
  assign res_o.truncated       = trunc;
  assign res_o.packets_seen    = 32'(pkt_total_d);
  assign res_o.errors_seen     = 32'(err_total_d);
  assign res_o.last_good_index = good_d;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INDEX;
      pos_q       <= 2'd0;
      gather_q    <= 24'd0;
      remain_q    <= 32'd0;
      xor_q       <= 32'd0;
      expect_q    <= 32'd0;
      index_q     <= 32'd0;
      pkt_total_q <= '0;
      err_total_q <= '0;
      good_q      <= 32'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      gather_q    <= gather_d;
      remain_q    <= remain_d;
      xor_q       <= xor_d;
      expect_q    <= expect_d;
      index_q     <= index_d;
      pkt_total_q <= pkt_total_d;
      err_total_q <= err_total_d;
      good_q      <= good_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pxcc_out_stage.sv]
// pxcc_out_stage: output register holding one report request
// depends on pxcc_pkg for the output request struct
`default_nettype none

module pxcc_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire pxcc_pkg::pxcc_out_t res_i,
  output logic                     adv_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pxcc_pkg::pxcc_out_t      out_data_o
);
  import pxcc_pkg::*;

  logic      valid_q, valid_d;
  pxcc_out_t data_q;

  // register can take a new result when empty or being drained
  assign adv_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

[hw/rtl/packet_xor_checksum_checker_top.sv]
// packet_xor_checksum_checker_top: byte-stream packet checksum checker
// uses pxcc_pkg, pxcc_in_stage, pxcc_parser, pxcc_out_stage
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one stream byte per
// request, with end_of_buffer set on the last byte of the buffer. Packets are
// three big-endian header words (index, checksum, payload length) plus payload.
// Output channel (out_valid_o / out_ready_i / out_data_o): one report request
// per finished or truncated packet with index, pass flag, truncation flag and
// running packet, error and last-good-index totals.
// Throughput: one byte per cycle while the receiver does not stall, limited by
// the parser step between the input register and the output register.
// Path: a packet's last byte goes from the input register through the parser
// step, and its report is loaded into the output register (two register stages).
// Reset: parser waits for an index word, all totals clear to zero.
// Receiver stall: the output register holds its report and the parser pauses;
// the input register keeps at most one waiting byte, and in_ready_o stays low
// while it is full, until the report is taken.
`default_nettype none

module packet_xor_checksum_checker_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pxcc_pkg::pxcc_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pxcc_pkg::pxcc_out_t      out_data_o
);
  import pxcc_pkg::*;

  logic      held_valid;
  pxcc_in_t  held_data;
  logic      adv;
  logic      step;
  logic      res_valid;
  pxcc_out_t res;

  // parser steps when a byte is held and the output side can advance
  assign step = held_valid && adv;

  pxcc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .take_i       (step),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  pxcc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (held_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pxcc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
